### src/vtu_pkg.sv
`timescale 1ns / 1ps
package vtu_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned MAT_N  = 4;
    localparam int unsigned NUM_MAT = 4;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word t_vec4 [MAT_N];
    typedef t_word t_mat4 [MAT_N*MAT_N];

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_VERTEX = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MAT_PROJ  = 2'd0,
        MAT_VIEW  = 2'd1,
        MAT_MODEL = 2'd2,
        MAT_SCALE = 2'd3
    } t_mat_sel;

    typedef struct packed {
        logic [0:0]        op;
        logic [1:0]        matrix_select;
        logic [3:0]        element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } t_vtu_in;

    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [31:0] world_w;
        logic signed [31:0] out_normal_x;
        logic signed [31:0] out_normal_y;
        logic signed [31:0] out_normal_z;
    } t_vtu_out;

    // Saturate a wide sum to a signed 32-bit word
    function automatic t_word sat32(input logic signed [WORD_W+3:0] v);
        if (v > $signed({{4{1'b0}}, 1'b0, {(WORD_W-1){1'b1}}}))
            return {1'b0, {(WORD_W-1){1'b1}}};
        else if (v < $signed({{4{1'b1}}, 1'b1, {(WORD_W-1){1'b0}}}))
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return v[WORD_W-1:0];
    endfunction
endpackage

### src/vtu_if.sv
`timescale 1ns / 1ps
interface vtu_in_if;
    logic valid;
    logic ready;
    vtu_pkg::t_vtu_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vtu_out_if;
    logic valid;
    logic ready;
    vtu_pkg::t_vtu_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/vtu_mat_stage.sv
`timescale 1ns / 1ps
// Matrix-vector stage: register the products, then sum and saturate.
module vtu_mat_stage #(
    parameter int FRAC_BITS = 16,
    parameter int ROWS = 4
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  vtu_pkg::t_mat4      i_mat,
    input  vtu_pkg::t_vec4      i_vec,
    output vtu_pkg::t_vec4      o_vec
);
    import vtu_pkg::*;

    localparam int PW = 2 * WORD_W;

    logic signed [PW-FRAC_BITS-1:0] r_prod [MAT_N][MAT_N];
    t_vec4 r_out;

    // Multiply each element by its vector term, floor-shift by the fraction; terms outside ROWS are zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < MAT_N; r++) begin
                for (int c = 0; c < MAT_N; c++) begin
                    logic signed [PW-1:0] p;
                    p = $signed(i_mat[c*MAT_N+r]) * $signed(i_vec[c]);
                    r_prod[r][c] <= (r < ROWS && c < ROWS) ? p[PW-1:FRAC_BITS] : '0;
                end
            end
        end
    end

    // Sum the row and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < MAT_N; r++) begin
                logic signed [PW-FRAC_BITS+1:0] acc;
                acc = '0;
                for (int c = 0; c < MAT_N; c++)
                    acc = acc + (PW-FRAC_BITS+2)'(r_prod[r][c]);
                if (acc > $signed((PW-FRAC_BITS+2)'(32'sh7fffffff)))
                    r_out[r] <= 32'sh7fffffff;
                else if (acc < $signed(-(PW-FRAC_BITS+2)'(64'sh80000000)))
                    r_out[r] <= 32'sh80000000;
                else
                    r_out[r] <= acc[WORD_W-1:0];
            end
        end
    end

    assign o_vec = r_out;
endmodule

### src/vertex_transform_unit.sv
`timescale 1ns / 1ps
// One vertex per cycle while the pipeline advances; the pipeline advances
// as one whenever the output register is empty or being taken.
// Load transactions write one matrix element and give no result.
// Reset (synchronous, active low) clears valid bits and sets identity matrices.
module vertex_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vtu_in_if.sink    i_in,
    vtu_out_if.source o_out
);
    import vtu_pkg::*;

    // Eight stages of matrix work plus the output register
    localparam int NST = 9;
    // Stage at which world and normal work starts
    localparam int WN_TAP = 6;

    t_mat4 r_mat [NUM_MAT];
    logic [NST:0] r_vld;
    logic adv;
    t_vec4 r_pos [WN_TAP+1];
    t_vec4 r_nrm [WN_TAP+1];
    t_vec4 s_in, m_in, v_in, p_in, c_out, w_out, n_out, w_in, n_in;

    assign adv = !r_vld[NST] || o_out.ready;
    assign i_in.ready = adv;

    // Store matrix elements; identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_MAT; k++)
                for (int e = 0; e < MAT_N*MAT_N; e++)
                    r_mat[k][e] <= (e % 5 == 0) ? t_word'(1 <<< FRAC_BITS) : '0;
        end else if (i_in.valid && adv && i_in.data.op == OP_LOAD) begin
            r_mat[i_in.data.matrix_select][i_in.data.element_index] <=
                i_in.data.element_value;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-1:0], i_in.valid && i_in.data.op == OP_VERTEX};
        end
    end

    // Carry input vectors down the pipe
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos[0] <= '{i_in.data.pos_x, i_in.data.pos_y, i_in.data.pos_z,
                          i_in.data.pos_w};
            r_nrm[0] <= '{i_in.data.normal_x, i_in.data.normal_y,
                          i_in.data.normal_z, '0};
            for (int s = 1; s <= WN_TAP; s++) begin
                r_pos[s] <= r_pos[s-1];
                r_nrm[s] <= r_nrm[s-1];
            end
        end
    end

    assign s_in = r_pos[0];
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_s (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_SCALE]), .i_vec(s_in), .o_vec(m_in));
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_m (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_MODEL]), .i_vec(m_in), .o_vec(v_in));
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_v (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_VIEW]), .i_vec(v_in), .o_vec(p_in));
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_p (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_PROJ]), .i_vec(p_in), .o_vec(c_out));

    // World and normal in the last two stages so they line up with clip
    assign w_in = r_pos[WN_TAP];
    assign n_in = r_nrm[WN_TAP];
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(4)) u_w (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_MODEL]), .i_vec(w_in), .o_vec(w_out));
    vtu_mat_stage #(.FRAC_BITS(FRAC_BITS), .ROWS(3)) u_n (
        .i_clk(i_clk), .i_en(adv), .i_mat(r_mat[MAT_MODEL]), .i_vec(n_in), .o_vec(n_out));

    // Output register
    t_vtu_out r_res;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= '{c_out[0], c_out[1], c_out[2], c_out[3],
                       w_out[0], w_out[1], w_out[2], w_out[3],
                       n_out[0], n_out[1], n_out[2]};
        end
    end

    assign o_out.valid = r_vld[NST];
    assign o_out.data  = r_res;
endmodule

### src/vtu_checker.sv
`timescale 1ns / 1ps
module vtu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input vtu_pkg::t_vtu_out out_data
);
    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // Accept input whenever output is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready) else $error("stalled with free output");
    // Nothing comes out straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind vertex_transform_unit vtu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data));
